>>> rtl/core/brpd_pkg.sv
package brpd_pkg;

  // Filter and peak ring geometry.
  localparam int AVG_TAPS   = 5;
  localparam int PEAK_SLOTS = 10;

  // Millivolt conversion: mv = raw * MV_SCALE / ADC_FULL, truncated toward zero.
  localparam int MV_SCALE = 3600;
  localparam int ADC_SH   = 12;
  localparam int ADC_FULL = 2 ** ADC_SH;
  localparam int MV_MAX   = 3599;

  localparam int RAW_W  = 13;
  localparam int MV_W   = 13;
  localparam int PROD_W = RAW_W + 12;
  localparam int FILT_W = 14;
  localparam int TIME_W = 32;
  localparam int RATE_W = 16;

  // Boxcar sum and its magnitude.
  localparam int SUM_W   = $clog2(AVG_TAPS * MV_MAX + 1) + 1;
  localparam int MAG_W   = SUM_W - 1;
  localparam int WSLOT_W = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;

  // Division of the sum by AVG_TAPS through a reciprocal multiply.
  localparam int DIV_SH = MAG_W + $clog2(AVG_TAPS);
  localparam int DIV_M  = (2 ** DIV_SH + AVG_TAPS - 1) / AVG_TAPS;
  localparam int AVGP_W = MAG_W + DIV_SH;

  // Peak ring.
  localparam int PSLOT_W = $clog2(PEAK_SLOTS);
  localparam int CNT_W   = $clog2(PEAK_SLOTS + 1);

  // Rate numerator: RATE_NUM * (count - 1).
  localparam int RATE_NUM = 6000000;
  localparam int NUM_W    = $clog2(RATE_NUM * (PEAK_SLOTS - 1) + 1);
  localparam int QCNT_W   = $clog2(NUM_W + 1);
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Configuration registers.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP  = 2'd2;

  localparam int BASE_W = 12;
  localparam int THR_W  = 10;
  localparam int GAP_W  = 16;
  localparam logic [BASE_W-1:0] BASELINE_RST = 12'd2100;
  localparam logic [THR_W-1:0]  RISE_THR_RST = 10'd10;
  localparam logic [GAP_W-1:0]  MIN_GAP_RST  = 16'd1500;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] den;
  } brpd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } brpd_div_rsp_t;

endpackage

>>> rtl/core/breathing_rate_peak_detector_top.sv
// Each request passes the window, average and detection states; when a rate is wanted
// the span is checked, and equal peak times saturate the rate, else the serial rate
// divider runs, retiring one quotient bit per cycle. A new request is taken only
// once the previous one has reached the output register.
// Reset (rst_n, synchronous, active low) restores the register defaults, empties the
// filter window and the peak count; no clearing pass is needed.
module breathing_rate_peak_detector_top
  import brpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_sample_raw,
  input  logic [TIME_W-1:0]       in_time_ms,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [FILT_W-1:0] out_filtered_mv,
  output logic                     out_peak_accepted,
  output logic                     out_rate_valid,
  output logic [RATE_W-1:0]        out_rate_centi_bpm,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // The request walks through a short sequence: window update, reciprocal multiply,
  // detection and ring update, then, when an accepted peak leaves two or more stored,
  // the span check and the rate division. Results wait in an output register so that
  // a new request can be taken while the previous result is still pending downstream.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WIN  = 7'b0000010,
    S_AVG  = 7'b0000100,
    S_DET  = 7'b0001000,
    S_SPAN = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } brpd_state_t;

  brpd_state_t state_r, state_nxt;

  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce it.
  logic [BASE_W-1:0] baseline_r;
  logic [THR_W-1:0]  rise_thr_r;
  logic [GAP_W-1:0]  min_gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= BASELINE_RST;
      rise_thr_r <= RISE_THR_RST;
      min_gap_r  <= MIN_GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASELINE: baseline_r <= cfg_data[BASE_W-1:0];
        CFG_RISE_THR: rise_thr_r <= cfg_data[THR_W-1:0];
        CFG_MIN_GAP:  min_gap_r  <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  wire in_fire = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // Millivolt conversion. The bias of 4095 on negative products turns the
  // arithmetic shift into a truncation toward zero.
  logic signed [PROD_W-1:0] mv_prod;
  logic signed [PROD_W-1:0] mv_adj;
  logic signed [MV_W-1:0]   mv_in;

  assign mv_prod = PROD_W'(in_sample_raw) * PROD_W'(MV_SCALE);
  assign mv_adj  = mv_prod + (mv_prod[PROD_W-1] ? PROD_W'(ADC_FULL - 1) : '0);
  assign mv_in   = mv_adj[ADC_SH +: MV_W];

  logic signed [MV_W-1:0] mv_r;
  logic [TIME_W-1:0]      time_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mv_r   <= mv_in;
      time_r <= in_time_ms;
    end
  end

  // Filter window memory. Entries that were never written since reset read as zero
  // through their valid bits.
  logic signed [MV_W-1:0] win_mem [AVG_TAPS];
  logic [AVG_TAPS-1:0]    win_vld_r;
  logic signed [MV_W-1:0] win_rd_r;
  logic                   win_rd_vld_r;
  logic [WSLOT_W-1:0]     wslot_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [MV_W-1:0] win_old;

  // The read address is the slot pointer, which moves only in the window state, so
  // the word registered during the accepting cycle is the one being replaced.
  always_ff @(posedge clk) begin
    win_rd_r     <= win_mem[wslot_r];
    win_rd_vld_r <= win_vld_r[wslot_r];
    if (state_r == S_WIN) begin
      win_mem[wslot_r] <= mv_r;
    end
  end

  assign win_old = win_rd_vld_r ? win_rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= '0;
      wslot_r   <= '0;
      sum_r     <= '0;
    end else if (state_r == S_WIN) begin
      win_vld_r[wslot_r] <= 1'b1;
      wslot_r <= (wslot_r == WSLOT_W'(AVG_TAPS - 1)) ? '0 : wslot_r + 1'b1;
      sum_r   <= sum_r - SUM_W'(win_old) + SUM_W'(mv_r);
    end
  end

  // Average by reciprocal multiply on the magnitude, sign restored afterwards so that
  // the quotient truncates toward zero.
  logic [MAG_W-1:0]  sum_mag;
  logic [AVGP_W-1:0] avg_prod_r;
  logic              avg_neg_r;

  assign sum_mag = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);

  always_ff @(posedge clk) begin
    if (state_r == S_AVG) begin
      avg_prod_r <= AVGP_W'(sum_mag) * AVGP_W'(DIV_M);
      avg_neg_r  <= sum_r[SUM_W-1];
    end
  end

  localparam int EXT_W = MAG_W + 2;

  logic [MAG_W-1:0]         avg_mag;
  logic signed [EXT_W-1:0]  avg_ext;
  logic signed [EXT_W-1:0]  cur_ext;
  logic signed [FILT_W-1:0] cur;

  assign avg_mag = avg_prod_r[DIV_SH +: MAG_W];
  assign avg_ext = avg_neg_r ? -$signed(EXT_W'(avg_mag)) : $signed(EXT_W'(avg_mag));
  assign cur_ext = avg_ext - $signed(EXT_W'(baseline_r));
  assign cur     = cur_ext[FILT_W-1:0];

  // Hysteretic detector: arm on a rise above the threshold, report a peak at the
  // first fall. A peak too close to the last accepted one still disarms.
  logic signed [FILT_W-1:0] prev_r;
  logic                     rising_r;
  logic [TIME_W-1:0]        last_peak_r;
  logic [PSLOT_W-1:0]       pslot_r;
  logic [CNT_W-1:0]         cnt_r;

  logic signed [FILT_W+1:0] cur_w;
  logic signed [FILT_W+1:0] arm_lvl;
  logic                     peak;
  logic                     arm;
  logic                     gap_ok;
  logic                     accept;
  logic [TIME_W-1:0]        gap_elapsed;
  logic [CNT_W-1:0]         cnt_new;
  logic                     want_rate;

  assign cur_w       = (FILT_W + 2)'(cur);
  assign arm_lvl     = (FILT_W + 2)'(prev_r) + $signed((FILT_W + 2)'(rise_thr_r));
  assign peak        = rising_r && (cur < prev_r);
  assign arm         = !rising_r && (cur_w > arm_lvl);
  assign gap_elapsed = time_r - last_peak_r;
  assign gap_ok      = gap_elapsed >= TIME_W'(min_gap_r);
  assign accept      = peak && gap_ok;
  assign cnt_new     = (cnt_r == CNT_W'(PEAK_SLOTS)) ? cnt_r : cnt_r + 1'b1;
  assign want_rate   = accept && (cnt_new >= CNT_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      rising_r    <= 1'b0;
      last_peak_r <= '0;
      pslot_r     <= '0;
      cnt_r       <= '0;
    end else if (state_r == S_DET) begin
      prev_r <= cur;
      if (peak) begin
        rising_r <= 1'b0;
      end else if (arm) begin
        rising_r <= 1'b1;
      end
      if (accept) begin
        last_peak_r <= time_r;
        pslot_r <= (pslot_r == PSLOT_W'(PEAK_SLOTS - 1)) ? '0 : pslot_r + 1'b1;
        cnt_r   <= cnt_new;
      end
    end
  end

  // Peak time ring. The newest time is the one being written, so only the oldest
  // entry is read. When a rate is wanted, its slot lies between one and PEAK_SLOTS - 1
  // places behind the write slot, so the read and the write then never meet on the same entry.
  logic [TIME_W-1:0]  pk_mem [PEAK_SLOTS];
  logic [TIME_W-1:0]  pk_rd_r;
  logic [PSLOT_W:0]   old_sum;
  logic [PSLOT_W-1:0] old_idx;

  assign old_sum = {1'b0, pslot_r} + (PSLOT_W + 1)'(PEAK_SLOTS + 1) - (PSLOT_W + 1)'(cnt_new);
  assign old_idx = (old_sum >= (PSLOT_W + 1)'(PEAK_SLOTS)) ?
                   PSLOT_W'(old_sum - (PSLOT_W + 1)'(PEAK_SLOTS)) : PSLOT_W'(old_sum);

  always_ff @(posedge clk) begin
    pk_rd_r <= pk_mem[old_idx];
    if (state_r == S_DET && accept) begin
      pk_mem[pslot_r] <= time_r;
    end
  end

  // Rate: RATE_NUM * (count - 1) / span through the serial divider.
  logic [TIME_W-1:0] span;
  brpd_div_req_t     div_req;
  brpd_div_rsp_t     div_rsp;

  assign span          = time_r - pk_rd_r;
  assign div_req.start = (state_r == S_SPAN) && (span != '0);
  assign div_req.num   = NUM_W'(RATE_NUM) * NUM_W'(cnt_r - 1'b1);
  assign div_req.den   = span;

  brpd_rate_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Result being assembled for the current request.
  logic signed [FILT_W-1:0] res_filt_r;
  logic                     res_acc_r;
  logic                     res_rv_r;
  logic [RATE_W-1:0]        res_rate_r;

  always_ff @(posedge clk) begin
    case (state_r)
      S_DET: begin
        res_filt_r <= cur;
        res_acc_r  <= accept;
        res_rv_r   <= want_rate;
        res_rate_r <= '0;
      end
      S_SPAN: begin
        if (span == '0) begin
          res_rate_r <= RATE_MAX;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_rate_r <= (|div_rsp.quot[NUM_W-1:RATE_W]) ? RATE_MAX :
                        div_rsp.quot[RATE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  wire out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_WIN;
      S_WIN:  state_nxt = S_AVG;
      S_AVG:  state_nxt = S_DET;
      S_DET:  state_nxt = want_rate ? S_SPAN : S_DONE;
      S_SPAN: state_nxt = (span == '0) ? S_DONE : S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_filtered_mv    <= res_filt_r;
      out_peak_accepted  <= res_acc_r;
      out_rate_valid     <= res_rv_r;
      out_rate_centi_bpm <= res_rate_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/brpd_rate_div.sv
module brpd_rate_div
  import brpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  brpd_div_req_t req,
  output brpd_div_rsp_t rsp
);

  // Restoring division, one quotient bit per cycle, MSB first.
  logic                busy_r;
  logic                done_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [TIME_W-1:0]   den_r;
  logic [TIME_W-1:0]   rem_r;
  logic [NUM_W-1:0]    quo_r;
  logic [TIME_W:0]     trial;
  logic [TIME_W:0]     diff;
  logic                ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= QCNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == QCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= req.num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule
